### rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the parent candidate table
// Table entry layout, controller command and status groups, state encoding,
// command and register codes and the reset values of registers and entries.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_PICK   = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RSSI   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT = 2'd2;

  localparam logic signed [8:0] MIN_RSSI_RST    = -9'sd120;
  localparam logic [7:0]        MAX_HOPS_RST    = 8'd6;
  localparam logic [31:0]       STALE_LIMIT_RST = 32'd90000;

  localparam logic [7:0] NO_PARENT = 8'hFF;

  typedef struct packed {
    logic [7:0]        node;
    logic signed [8:0] signal;
    logic [7:0]        hops;
    logic [31:0]       seen;
  } entry_t;

  localparam entry_t ENTRY_RST = '{node: 8'hFF, signal: -9'sd127, hops: 8'hFF,
                                   seen: 32'd0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic proc_en;
    logic wr_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pass;
    logic pick;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/core/pct_if.sv
// ----------------------------------------------------------------------------
// pct_if: request and response channels of the parent candidate table
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pct_req_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [31:0]       now_ms;
  logic [7:0]        node_id;
  logic signed [8:0] signal_dbm;
  logic [7:0]        hop_count;

  modport source (output valid, command, now_ms, node_id, signal_dbm, hop_count,
                  input ready);
  modport sink (input valid, command, now_ms, node_id, signal_dbm, hop_count,
                output ready);
endinterface

interface pct_rsp_if;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [7:0]        parent_id;
  logic signed [8:0] parent_dbm;
  logic              found;

  modport source (output valid, accepted, parent_id, parent_dbm, found,
                  input ready);
  modport sink (input valid, accepted, parent_id, parent_dbm, found,
                output ready);
endinterface

`default_nettype wire

### rtl/core/pct_ram.sv
// ----------------------------------------------------------------------------
// pct_ram: generic single write port RAM with registered read
// One write and one read per cycle; read data appears the cycle after re.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl: sequencer of the parent candidate table
// Accepts one transaction, sweeps the table one entry a cycle, writes the
// chosen slot for a stored update and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_ctrl #(
  parameter int NUM_ENTRIES = 8,
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire pct_pkg::ctrl_status_t status,
  output logic                       in_ready,
  output pct_pkg::ctrl_cmd_t         cmd,
  output logic [CNT_W-1:0]           scan_cnt
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_ENTRIES);

  pct_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pct_pkg::ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == pct_pkg::ST_SCAN && scan_cnt != LAST) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pct_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pct_pkg::ST_SCAN;
        end
      end
      pct_pkg::ST_SCAN: begin
        if (scan_cnt == LAST) begin
          if (status.pass && !status.pick) begin
            state_next = pct_pkg::ST_WRITE;
          end else begin
            state_next = pct_pkg::ST_FINISH;
          end
        end
      end
      pct_pkg::ST_WRITE: begin
        state_next = pct_pkg::ST_FINISH;
      end
      pct_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_next = pct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state == pct_pkg::ST_IDLE);
    cmd.load     = in_ready && in_valid;
    cmd.rd_en    = (state == pct_pkg::ST_SCAN) && (scan_cnt != LAST);
    cmd.proc_en  = (state == pct_pkg::ST_SCAN) && (scan_cnt != '0);
    cmd.wr_en    = (state == pct_pkg::ST_WRITE);
    cmd.out_load = (state == pct_pkg::ST_FINISH) && status.out_free;
  end

endmodule

`default_nettype wire

### rtl/core/pct_datapath.sv
// ----------------------------------------------------------------------------
// pct_datapath: table storage, entry evaluation and result register
// Holds the configuration and the current transaction, tracks the matching
// or oldest slot and the best fresh candidate as entries stream out of RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_datapath #(
  parameter int NUM_ENTRIES = 8,
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pct_pkg::ctrl_cmd_t                cmd,
  input  wire logic [CNT_W-1:0]                  scan_cnt,
  output pct_pkg::ctrl_status_t                  status,
  input  wire logic                              cfg_we,
  input  wire logic [pct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_command,
  input  wire logic [31:0]                       in_now_ms,
  input  wire logic [7:0]                        in_node_id,
  input  wire logic signed [8:0]                 in_signal_dbm,
  input  wire logic [7:0]                        in_hop_count,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic                                   out_accepted,
  output logic [7:0]                             out_parent_id,
  output logic signed [8:0]                      out_parent_dbm,
  output logic                                   out_found
);

  logic signed [8:0] min_rssi;
  logic [7:0]        max_hop_count;
  logic [31:0]       stale_limit_ms;

  logic              item_cmd;
  logic [31:0]       item_now;
  logic [7:0]        item_id;
  logic signed [8:0] item_sig;
  logic [7:0]        item_hops;

  logic [NUM_ENTRIES-1:0] entry_valid;
  logic                   rd_valid;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       proc_idx;
  logic [IDX_W-1:0]       wr_slot;
  pct_pkg::entry_t        ram_q;
  pct_pkg::entry_t        ent;
  pct_pkg::entry_t        wr_entry;

  logic              match_found;
  logic [IDX_W-1:0]  match_slot;
  logic [IDX_W-1:0]  oldest_slot;
  logic [31:0]       oldest_seen;

  logic              best_found;
  logic [7:0]        best_node;
  logic signed [8:0] best_sig;
  logic [7:0]        best_hops;

  logic [31:0] age;
  logic        fresh;
  logic        better;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rssi       <= pct_pkg::MIN_RSSI_RST;
      max_hop_count  <= pct_pkg::MAX_HOPS_RST;
      stale_limit_ms <= pct_pkg::STALE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pct_pkg::CFG_MIN_RSSI:    min_rssi       <= cfg_data[8:0];
        pct_pkg::CFG_MAX_HOPS:    max_hop_count  <= cfg_data[7:0];
        pct_pkg::CFG_STALE_LIMIT: stale_limit_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd  <= in_command;
      item_now  <= in_now_ms;
      item_id   <= in_node_id;
      item_sig  <= in_signal_dbm;
      item_hops <= in_hop_count;
    end
  end

  assign rd_addr  = scan_cnt[IDX_W-1:0];
  assign wr_slot  = match_found ? match_slot : oldest_slot;
  assign wr_entry = '{node: item_id, signal: item_sig, hops: item_hops, seen: item_now};

  pct_ram #(
    .WIDTH ($bits(pct_pkg::entry_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_slot),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.wr_en) begin
      entry_valid[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid <= entry_valid[rd_addr];
      proc_idx <= rd_addr;
    end
  end

  assign ent = rd_valid ? ram_q : pct_pkg::ENTRY_RST;

  always_comb begin
    age    = item_now - ent.seen;
    fresh  = (age <= stale_limit_ms);
    better = (ent.signal > best_sig) ||
             ((ent.signal == best_sig) && (ent.hops < best_hops)) ||
             ((ent.signal == best_sig) && (ent.hops == best_hops) &&
              (ent.node < best_node));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmd.load) begin
      match_found <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmd.proc_en) begin
      if (!match_found && ent.node == item_id) begin
        match_found <= 1'b1;
      end
      if (fresh && (!best_found || better)) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.proc_en) begin
      if (!match_found) begin
        if (ent.node == item_id) begin
          match_slot <= proc_idx;
        end else if (proc_idx == '0 || ent.seen < oldest_seen) begin
          oldest_slot <= proc_idx;
          oldest_seen <= ent.seen;
        end
      end
      if (fresh && (!best_found || better)) begin
        best_node <= ent.node;
        best_sig  <= ent.signal;
        best_hops <= ent.hops;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (item_cmd == pct_pkg::CMD_PICK) begin
        out_accepted   <= 1'b0;
        out_found      <= best_found;
        out_parent_id  <= best_found ? best_node : pct_pkg::NO_PARENT;
        out_parent_dbm <= best_found ? best_sig : 9'sd0;
      end else begin
        out_accepted   <= status.pass;
        out_found      <= 1'b0;
        out_parent_id  <= pct_pkg::NO_PARENT;
        out_parent_dbm <= 9'sd0;
      end
    end
  end

  always_comb begin
    status.pass     = (item_sig >= min_rssi) && (item_hops <= max_hop_count);
    status.pick     = (item_cmd == pct_pkg::CMD_PICK);
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### rtl/core/parent_candidate_table.sv
// Each request is taken only while idle; the table is then swept through the single
// read port of the table RAM, one entry is read a cycle, a stored update is written
// and the result is handed to the response register once any pending reply is taken.
// A new transaction is not accepted until the previous one has been handed over.
// Reset: synchronous; registers return to their defaults and all entries read
// as id 255, -127 dBm, 255 hops, seen at time 0, with no clearing pass.
// ----------------------------------------------------------------------------
// parent_candidate_table: neighbour table with best parent selection
// Updates store or refresh a candidate; picks return the best fresh entry.
// ----------------------------------------------------------------------------
`default_nettype none

module parent_candidate_table #(
  parameter int NUM_ENTRIES = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pct_req_if.sink                             request,
  pct_rsp_if.source                           response,
  input  wire logic                           cfg_we,
  input  wire logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pct_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  pct_pkg::ctrl_cmd_t    ctrl_cmd;
  pct_pkg::ctrl_status_t ctrl_status;
  logic [CNT_W-1:0]      scan_cnt;

  pct_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .status   (ctrl_status),
    .in_ready (request.ready),
    .cmd      (ctrl_cmd),
    .scan_cnt (scan_cnt)
  );

  pct_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctrl_cmd),
    .scan_cnt       (scan_cnt),
    .status         (ctrl_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (request.command),
    .in_now_ms      (request.now_ms),
    .in_node_id     (request.node_id),
    .in_signal_dbm  (request.signal_dbm),
    .in_hop_count   (request.hop_count),
    .out_ready      (response.ready),
    .out_valid      (response.valid),
    .out_accepted   (response.accepted),
    .out_parent_id  (response.parent_id),
    .out_parent_dbm (response.parent_dbm),
    .out_found      (response.found)
  );

`ifndef SYNTHESIS
  a_write_only_stored_update : assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.wr_en |-> ctrl_status.pass && !ctrl_status.pick)
    else $error("Table written for a pick or a rejected update.");

  a_no_result_overwrite : assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.out_load |-> !response.valid || response.ready)
    else $error("Pending response overwritten.");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("Second transaction accepted while one is in progress.");

  a_no_scan_while_idle : assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !ctrl_cmd.rd_en && !ctrl_cmd.wr_en)
    else $error("Table accessed while waiting for a request.");
`endif

endmodule

`default_nettype wire

### tb/parent_candidate_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parent_candidate_table_test: self-checking bench for the parent table
// Requests come from a queue through a bursty driver. A model of the
// neighbour table works out the reply to each accepted request. A monitor
// with its own stall pattern checks every reply against the oldest one that
// is still outstanding. The limit registers are changed between phases while
// the block is idle, among them the extremes, random settings and the defaults.
// ----------------------------------------------------------------------------

module parent_candidate_table_test;

  localparam int TABLE_DEPTH  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 700;

  typedef struct {
    logic              command;
    logic [31:0]       now_ms;
    logic [7:0]        node_id;
    logic signed [8:0] signal_dbm;
    logic [7:0]        hop_count;
  } command_t;

  typedef struct {
    logic              accepted;
    logic [7:0]        parent_id;
    logic signed [8:0] parent_dbm;
    logic              found;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we;
  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data;

  pct_req_if request ();
  pct_rsp_if response ();

  parent_candidate_table #(
    .NUM_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .request(request),
    .response(response),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  pct_pkg::entry_t   neighbours [TABLE_DEPTH];
  logic signed [8:0] lim_rssi;
  logic [7:0]        lim_hops;
  logic [31:0]       lim_stale;
  logic [31:0]       clock_ms;

  command_t queued_commands [$];
  reply_t   pending_replies [$];
  command_t offer;

  int error_count = 0;
  int replies_seen = 0;
  int accepted_count = 0;
  int update_count = 0;
  int stored_count = 0;
  int pick_count = 0;
  int parent_count = 0;
  int settings_used = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int pattern_age = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  function automatic reply_t apply_to_table(command_t c);
    reply_t r;
    int slot;
    int oldest;
    int best;
    logic [31:0] age;
    r.accepted   = 1'b0;
    r.parent_id  = pct_pkg::NO_PARENT;
    r.parent_dbm = '0;
    r.found      = 1'b0;
    if (c.command == pct_pkg::CMD_UPDATE) begin
      if (c.signal_dbm >= lim_rssi && c.hop_count <= lim_hops) begin
        slot = -1;
        oldest = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot < 0) begin
            if (neighbours[i].node == c.node_id) begin
              slot = i;
            end else if (neighbours[i].seen < neighbours[oldest].seen) begin
              oldest = i;
            end
          end
        end
        if (slot < 0) slot = oldest;
        neighbours[slot].node   = c.node_id;
        neighbours[slot].signal = c.signal_dbm;
        neighbours[slot].hops   = c.hop_count;
        neighbours[slot].seen   = c.now_ms;
        r.accepted = 1'b1;
      end
    end else begin
      best = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        age = c.now_ms - neighbours[i].seen;
        if (age <= lim_stale) begin
          if (best < 0) begin
            best = i;
          end else if (neighbours[i].signal != neighbours[best].signal) begin
            if (neighbours[i].signal > neighbours[best].signal) best = i;
          end else if (neighbours[i].hops != neighbours[best].hops) begin
            if (neighbours[i].hops < neighbours[best].hops) best = i;
          end else if (neighbours[i].node < neighbours[best].node) begin
            best = i;
          end
        end
      end
      if (best >= 0) begin
        r.parent_id  = neighbours[best].node;
        r.parent_dbm = neighbours[best].signal;
        r.found      = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic command_t make_cmd(logic cmd, logic [31:0] now, logic [7:0] id,
                                        logic signed [8:0] sig, logic [7:0] hops);
    command_t c;
    c.command    = cmd;
    c.now_ms     = now;
    c.node_id    = id;
    c.signal_dbm = sig;
    c.hop_count  = hops;
    return c;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int s;
    int lo;
    int idx;
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom();
      1, 2:    clock_ms = clock_ms + $urandom_range(0, 200000);
      3, 4, 5: clock_ms = clock_ms;
      default: clock_ms = clock_ms + $urandom_range(0, 3000);
    endcase
    c.now_ms  = clock_ms;
    c.command = ($urandom_range(0, 9) < 3) ? pct_pkg::CMD_PICK : pct_pkg::CMD_UPDATE;
    case ($urandom_range(0, 9))
      0:       c.node_id = pct_pkg::NO_PARENT;
      1:       c.node_id = 8'($urandom_range(250, 254));
      2:       c.node_id = 8'($urandom());
      default: c.node_id = 8'($urandom_range(0, 11));
    endcase
    lo = int'(lim_rssi);
    if ($urandom_range(0, 4) == 0) begin
      s = $urandom();
    end else begin
      s = lo + int'($urandom_range(0, 255 - lo));
    end
    c.signal_dbm = s[8:0];
    c.hop_count  = ($urandom_range(0, 4) == 0) ? 8'($urandom()) :
                   8'($urandom_range(0, lim_hops));
    if (c.command == pct_pkg::CMD_PICK && $urandom_range(0, 4) == 0) begin
      idx = $urandom_range(0, TABLE_DEPTH - 1);
      c.now_ms = neighbours[idx].seen + lim_stale + $urandom_range(0, 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("reply %0d: %s is %0d, should be %0d", replies_seen, field, got, want);
    error_count++;
  endtask

  task automatic settle();
    while (queued_commands.size() != 0 || request.valid || pending_replies.size() != 0) begin
      @(negedge clk);
    end
    repeat (TABLE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic set_limits(logic signed [8:0] rssi, logic [7:0] hops, logic [31:0] stale);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pct_pkg::CFG_MIN_RSSI;
    cfg_data  <= {{23{rssi[8]}}, rssi};
    @(posedge clk);
    cfg_index <= pct_pkg::CFG_MAX_HOPS;
    cfg_data  <= {24'd0, hops};
    @(posedge clk);
    cfg_index <= pct_pkg::CFG_STALE_LIMIT;
    cfg_data  <= stale;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_rssi  = rssi;
    lim_hops  = hops;
    lim_stale = stale;
    settings_used++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive
    reply_t outcome;
    if (rst) begin
      request.valid <= 1'b0;
    end else begin
      if (request.valid && request.ready) begin
        outcome = apply_to_table(offer);
        pending_replies.push_back(outcome);
        accepted_count++;
        if (offer.command == pct_pkg::CMD_UPDATE) begin
          update_count++;
          stored_count += int'(outcome.accepted);
        end else begin
          pick_count++;
          parent_count += int'(outcome.found);
        end
      end
      if (!request.valid || request.ready) begin
        if (gap_left > 0 || queued_commands.size() == 0) begin
          if (gap_left > 0) gap_left--;
          request.valid <= 1'b0;
        end else begin
          offer = queued_commands.pop_front();
          request.valid      <= 1'b1;
          request.command    <= offer.command;
          request.now_ms     <= offer.now_ms;
          request.node_id    <= offer.node_id;
          request.signal_dbm <= offer.signal_dbm;
          request.hop_count  <= offer.hop_count;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      response.ready <= 1'b0;
    end else begin
      if (response.valid && response.ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unrequested reply, parent_id", int'(response.parent_id),
                          int'(pct_pkg::NO_PARENT));
        end else begin
          want = pending_replies.pop_front();
          if (response.accepted !== want.accepted)
            report_mismatch("accepted", int'(response.accepted), int'(want.accepted));
          if (response.parent_id !== want.parent_id)
            report_mismatch("parent_id", int'(response.parent_id), int'(want.parent_id));
          if (response.parent_dbm !== want.parent_dbm)
            report_mismatch("parent_dbm", int'(response.parent_dbm), int'(want.parent_dbm));
          if (response.found !== want.found)
            report_mismatch("found", int'(response.found), int'(want.found));
        end
        replies_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        response.ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        response.ready <= 1'b0;
      end else begin
        pattern_age++;
        if (pattern_age >= 64) begin
          pattern_age = 0;
          case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom() | $urandom());
            default: ready_pattern = 16'($urandom());
          endcase
        end
        response.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  initial begin : stimulus
    logic signed [8:0] rssi;
    logic [7:0]        hops;
    logic [31:0]       stale;
    int                count;
    cfg_we             = 1'b0;
    cfg_index          = pct_pkg::CFG_MIN_RSSI;
    cfg_data           = '0;
    request.valid      = 1'b0;
    request.command    = pct_pkg::CMD_UPDATE;
    request.now_ms     = '0;
    request.node_id    = '0;
    request.signal_dbm = '0;
    request.hop_count  = '0;
    response.ready     = 1'b0;
    lim_rssi  = pct_pkg::MIN_RSSI_RST;
    lim_hops  = pct_pkg::MAX_HOPS_RST;
    lim_stale = pct_pkg::STALE_LIMIT_RST;
    for (int i = 0; i < TABLE_DEPTH; i++) neighbours[i] = pct_pkg::ENTRY_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'd0, 8'd0, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd10, 8'd255, -9'sd50, 8'd1));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd15, 8'd5, -9'sd121, 8'd2));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd16, 8'd5, -9'sd40, 8'd7));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd17, 8'd5, 9'sd10, 8'd255));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd20, 8'd3, -9'sd120, 8'd6));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd30, 8'd7, 9'sd255, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd35, 8'd8, -9'sd256, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'd40, 8'd255, -9'sd1, 8'd255));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd50, 8'd7, 9'sd100, 8'd3));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd60, 8'd9, 9'sd100, 8'd2));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'd70, 8'd4, 9'sd100, 8'd2));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'd80, 8'd0, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'd90010, 8'd0, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'd90011, 8'd0, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'hFFFF_FFFF, 8'd0, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'hFFFF_FFF0, 8'd20, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'd5, 8'd0, 9'sd0, 8'd0));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'h8000_0000, 8'd0, -9'sd1, 8'd6));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'h8000_0001, 8'd21, 9'sd0, 8'd1));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'h8000_0002, 8'd22, 9'sd0, 8'd1));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_UPDATE, 32'h8000_0003, 8'd23, 9'sd0, 8'd1));
    queued_commands.push_back(make_cmd(pct_pkg::CMD_PICK, 32'h8000_0010, 8'd0, 9'sd0, 8'd0));
    settle();

    clock_ms = $urandom_range(0, 1000);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin rssi = -9'sd256; hops = 8'd255; stale = 32'hFFFF_FFFF; count = 400; end
        1: begin rssi = 9'sd255;  hops = 8'd0;   stale = 32'd0;         count = 100; end
        2: begin
          rssi = -9'sd100; hops = 8'd10; stale = 32'd5000; count = 400;
          clock_ms = 32'hFFFF_0000;
        end
        3: begin
          rssi = 9'($urandom()); hops = 8'($urandom()); stale = $urandom_range(0, 200000);
          count = 350;
        end
        4: begin rssi = -9'sd90; hops = 8'd3; stale = 32'd800; count = 350; end
        default: begin
          rssi  = pct_pkg::MIN_RSSI_RST;
          hops  = pct_pkg::MAX_HOPS_RST;
          stale = pct_pkg::STALE_LIMIT_RST;
          count = 330;
        end
      endcase
      set_limits(rssi, hops, stale);
      repeat (count) queued_commands.push_back(random_command());
      settle();
    end

    $display("Ran %0d transactions under %0d register settings: %0d updates (%0d stored),",
             accepted_count, settings_used + 1, update_count, stored_count);
    $display("%0d picks (%0d found a parent), with one %0d-cycle hold on the reply side.",
             pick_count, parent_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### parent_candidate_table.f
rtl/core/pct_pkg.sv
rtl/core/pct_if.sv
rtl/core/pct_ram.sv
rtl/core/pct_ctrl.sv
rtl/core/pct_datapath.sv
rtl/core/parent_candidate_table.sv
tb/parent_candidate_table_test.sv
